### src/iim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iim_pkg
// Shared types and constants for the interval insert-and-merge block.
// ----------------------------------------------------------------------------
package iim_pkg;

   // Most results one request can cause: emit before insert, emit before
   // the listed interval, and the final flush.
   localparam int RESULTS_MAX = 3;
   localparam int COUNT_WIDTH = $clog2(RESULTS_MAX + 1);

   // Bundle queue between front and back end
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NEW_START = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NEW_END   = 1'd1;

   // Control part of one result bundle
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;  // results in the bundle, 1..RESULTS_MAX
      logic                   close;  // final result of the bundle ends the list
   } bundle_ctl_type;

endpackage

### src/iim_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iim_front
// Classify each request against the pending interval and build its bundle.
// ----------------------------------------------------------------------------
module iim_front import iim_pkg::*; #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      accept,
   input  wire  [VALUE_WIDTH-1:0]                   iv_start,
   input  wire  [VALUE_WIDTH-1:0]                   iv_end,
   input  wire                                      no_interval,
   input  wire                                      list_last,
   input  wire  [VALUE_WIDTH-1:0]                   new_start,
   input  wire  [VALUE_WIDTH-1:0]                   new_end,
   output logic                                     push,
   output bundle_ctl_type                           push_ctl,
   output logic [RESULTS_MAX-1:0][VALUE_WIDTH-1:0]  push_starts,
   output logic [RESULTS_MAX-1:0][VALUE_WIDTH-1:0]  push_ends
);

   logic                   held_valid_ff, held_valid_in;
   logic [VALUE_WIDTH-1:0] held_start_ff, held_start_in;
   logic [VALUE_WIDTH-1:0] held_end_ff,   held_end_in;
   logic                   inserted_ff,   inserted_in;
   logic [COUNT_WIDTH-1:0] n_results;

   // Three ordered steps: new interval ahead of the item, the item itself,
   // new interval at the end of the list.
   always_comb begin : classify
      logic [2:0]                   step_en;
      logic [2:0]                   step_merge;
      logic [2:0][VALUE_WIDTH-1:0]  step_s;
      logic [2:0][VALUE_WIDTH-1:0]  step_e;
      logic                         ins_mid;
      logic                         hv;
      logic [VALUE_WIDTH-1:0]       hs;
      logic [VALUE_WIDTH-1:0]       he;
      logic [COUNT_WIDTH-1:0]       n;

      step_en[0]    = !no_interval && !inserted_ff && (iv_start > new_start);
      ins_mid       = inserted_ff || step_en[0];
      step_en[1]    = !no_interval;
      step_en[2]    = list_last && !ins_mid;
      step_merge    = {1'b1, ins_mid, 1'b1};
      step_s        = {new_start, iv_start, new_start};
      step_e        = {new_end, iv_end, new_end};

      hv = held_valid_ff;
      hs = held_start_ff;
      he = held_end_ff;
      n  = '0;
      push_starts = '0;
      push_ends   = '0;

      for (int k = 0; k < 3; k++) begin
         if (step_en[k]) begin
            if (step_merge[k] && hv && !(he < step_s[k])) begin
               // overlap or touch: widen the pending interval
               if (step_e[k] > he) begin
                  he = step_e[k];
               end
            end else begin
               if (hv) begin
                  push_starts[n[1:0]] = hs;
                  push_ends[n[1:0]]   = he;
                  n = n + 1'b1;
               end
               hv = 1'b1;
               hs = step_s[k];
               he = step_e[k];
            end
         end
      end

      inserted_in = ins_mid || step_en[2];
      if (list_last) begin
         // flush the pending interval and close the list
         push_starts[n[1:0]] = hs;
         push_ends[n[1:0]]   = he;
         n = n + 1'b1;
         hv = 1'b0;
         inserted_in = 1'b0;
      end

      held_valid_in = hv;
      held_start_in = hs;
      held_end_in   = he;
      n_results     = n;
   end

   assign push           = accept && (n_results != '0);
   assign push_ctl.count = n_results;
   assign push_ctl.close = list_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         inserted_ff   <= 1'b0;
      end else if (accept) begin
         held_valid_ff <= held_valid_in;
         inserted_ff   <= inserted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_start_ff <= held_start_in;
         held_end_ff   <= held_end_in;
      end
   end

endmodule
`default_nettype wire

### src/iim_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iim_queue
// Short register queue of result bundles between front and back end.
// ----------------------------------------------------------------------------
module iim_queue import iim_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire  [WIDTH-1:0] push_data,
   input  wire              pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data,
   output logic             full
);

   logic [QUEUE_DEPTH-1:0][WIDTH-1:0] slot_ff;
   logic [QPTR_WIDTH-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]             count_ff,  count_in;

   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign full       = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### src/iim_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iim_back
// Unroll each bundle into single results through the output register.
// ----------------------------------------------------------------------------
module iim_back import iim_pkg::*; #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      head_valid,
   input  bundle_ctl_type                           head_ctl,
   input  wire  [RESULTS_MAX-1:0][VALUE_WIDTH-1:0]  head_starts,
   input  wire  [RESULTS_MAX-1:0][VALUE_WIDTH-1:0]  head_ends,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output logic [VALUE_WIDTH-1:0]                   rsp_out_start,
   output logic [VALUE_WIDTH-1:0]                   rsp_out_end,
   output logic                                     rsp_out_last
);

   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_start_ff;
   logic [VALUE_WIDTH-1:0] rsp_end_ff;
   logic                   rsp_last_ff;
   logic [COUNT_WIDTH-1:0] idx_ff, idx_in;
   logic                   load;
   logic                   final_one;

   assign load      = !rsp_valid_ff || !rsp_stall;
   assign final_one = (idx_ff == head_ctl.count - 1'b1);
   assign pop       = load && head_valid && final_one;

   always_comb begin
      idx_in = idx_ff;
      if (load && head_valid) begin
         idx_in = final_one ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            rsp_valid_ff <= head_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         rsp_start_ff <= head_starts[idx_ff[1:0]];
         rsp_end_ff   <= head_ends[idx_ff[1:0]];
         rsp_last_ff  <= head_ctl.close && final_one;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_start = rsp_start_ff;
   assign rsp_out_end   = rsp_end_ff;
   assign rsp_out_last  = rsp_last_ff;

endmodule
`default_nettype wire

### src/interval_insert_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a request's bundle is queued, then its first result is registered out.
// Throughput: one request per cycle while each causes at most one result and
//   rsp_stall stays low; results leave one at a time (one result register).
// Reset: synchronous, clears the pending interval, the queue, the output valid
//   and both configuration registers (new interval 0..0).
// ----------------------------------------------------------------------------
// interval_insert_merge
// Insert a configured closed interval into a sorted interval stream and merge
// from the insertion point on.
// ----------------------------------------------------------------------------
module interval_insert_merge import iim_pkg::*; #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   // configuration write port
   input  wire                        csr_write_en,
   input  wire  [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [VALUE_WIDTH-1:0]     csr_wdata,
   // request channel
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [VALUE_WIDTH-1:0]     req_iv_start,
   input  wire  [VALUE_WIDTH-1:0]     req_iv_end,
   input  wire                        req_no_interval,
   input  wire                        req_list_last,
   // result channel
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [VALUE_WIDTH-1:0]     rsp_out_start,
   output logic [VALUE_WIDTH-1:0]     rsp_out_end,
   output logic                       rsp_out_last
);

   localparam int VALS_WIDTH = RESULTS_MAX * VALUE_WIDTH;
   localparam int CTL_WIDTH  = $bits(bundle_ctl_type);
   localparam int Q_WIDTH    = CTL_WIDTH + 2 * VALS_WIDTH;

   logic [VALUE_WIDTH-1:0] new_start_ff;
   logic [VALUE_WIDTH-1:0] new_end_ff;

   logic                                    req_accept;
   logic                                    push;
   bundle_ctl_type                          push_ctl;
   logic [RESULTS_MAX-1:0][VALUE_WIDTH-1:0] push_starts;
   logic [RESULTS_MAX-1:0][VALUE_WIDTH-1:0] push_ends;

   logic                                    q_full;
   logic                                    pop;
   logic                                    head_valid;
   logic [Q_WIDTH-1:0]                      head_data;
   bundle_ctl_type                          head_ctl;
   logic [RESULTS_MAX-1:0][VALUE_WIDTH-1:0] head_starts;
   logic [RESULTS_MAX-1:0][VALUE_WIDTH-1:0] head_ends;

   // Configuration registers; written only while the block is idle, which is up to the user.
   always_ff @(posedge clock) begin
      if (reset) begin
         new_start_ff <= '0;
         new_end_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_NEW_START: new_start_ff <= csr_wdata;
            CSR_NEW_END:   new_end_ff   <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // Hold the request off only when both queue slots are taken.
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   // Front end: track the pending interval, decide merge or emit for every
   // request and pack the results it causes into one bundle.
   iim_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .iv_start    (req_iv_start),
      .iv_end      (req_iv_end),
      .no_interval (req_no_interval),
      .list_last   (req_list_last),
      .new_start   (new_start_ff),
      .new_end     (new_end_ff),
      .push        (push),
      .push_ctl    (push_ctl),
      .push_starts (push_starts),
      .push_ends   (push_ends)
   );

   // Bundle queue: lets the front keep accepting while the back drains.
   iim_queue #(
      .WIDTH (Q_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_ctl, push_starts, push_ends}),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .full       (q_full)
   );

   assign head_ctl    = bundle_ctl_type'(head_data[Q_WIDTH-1 -: CTL_WIDTH]);
   assign head_starts = head_data[2*VALS_WIDTH-1 -: VALS_WIDTH];
   assign head_ends   = head_data[VALS_WIDTH-1:0];

   // Back end: send the bundle one result a cycle unless rsp_stall holds it;
   // advance the queue on its final result.
   iim_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_ctl      (head_ctl),
      .head_starts   (head_starts),
      .head_ends     (head_ends),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_start (rsp_out_start),
      .rsp_out_end   (rsp_out_end),
      .rsp_out_last  (rsp_out_last)
   );

endmodule
`default_nettype wire

### tb/sv/interval_insert_merge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_insert_merge_checker
// Watches the register port and both streams of the interval insert-and-merge
// block, predicts each result interval and compares results in arrival order.
// ----------------------------------------------------------------------------
module interval_insert_merge_checker import iim_pkg::*; #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_write_en,
   input  wire [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire [VALUE_WIDTH-1:0]     csr_wdata,
   input  wire                       req_valid,
   input  wire                       req_stall,
   input  wire [VALUE_WIDTH-1:0]     req_iv_start,
   input  wire [VALUE_WIDTH-1:0]     req_iv_end,
   input  wire                       req_no_interval,
   input  wire                       req_list_last,
   input  wire                       rsp_valid,
   input  wire                       rsp_stall,
   input  wire [VALUE_WIDTH-1:0]     rsp_out_start,
   input  wire [VALUE_WIDTH-1:0]     rsp_out_end,
   input  wire                       rsp_out_last,
   output int                        mismatch_count,
   output int                        results_pending,
   output int                        requests_seen,
   output int                        results_seen
);

   typedef logic [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      value_type lo;
      value_type hi;
      logic      last;
   } span_type;

   span_type  expected_spans[$];

   // mirror of the two registers
   value_type new_lo;
   value_type new_hi;

   // pending interval and insertion flag
   logic      held_valid;
   value_type held_lo;
   value_type held_hi;
   logic      new_placed;

   int     mismatches;
   int     n_requests;
   int     n_results;

   initial begin
      mismatch_count  = 0;
      results_pending = 0;
      requests_seen   = 0;
      results_seen    = 0;
      mismatches      = 0;
      n_requests      = 0;
      n_results       = 0;
   end

   task automatic report_mismatch(input string what, input value_type got,
                                  input value_type want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic emit_span(input value_type lo, input value_type hi, input logic last);
      span_type item;
      item.lo   = lo;
      item.hi   = hi;
      item.last = last;
      expected_spans.insert(expected_spans.size(), item);
   endtask

   task automatic append_plain(input value_type lo, input value_type hi);
      if (held_valid) emit_span(held_lo, held_hi, 1'b0);
      held_valid = 1'b1;
      held_lo    = lo;
      held_hi    = hi;
   endtask

   task automatic append_merge(input value_type lo, input value_type hi);
      if (!held_valid || held_hi < lo) append_plain(lo, hi);
      else if (hi > held_hi) held_hi = hi;
   endtask

   task automatic predict_merge_results(input value_type lo, input value_type hi,
                                        input logic none, input logic last);
      if (!none) begin
         if (!new_placed && lo > new_lo) begin
            append_merge(new_lo, new_hi);
            new_placed = 1'b1;
         end
         if (new_placed) append_merge(lo, hi);
         else append_plain(lo, hi);
      end
      if (last) begin
         if (!new_placed) append_merge(new_lo, new_hi);
         emit_span(held_lo, held_hi, 1'b1);
         held_valid = 1'b0;
         held_lo    = '0;
         held_hi    = '0;
         new_placed = 1'b0;
      end
   endtask

   always @(posedge clock) begin : watch
      span_type want;
      if (reset) begin
         expected_spans.delete();
         new_lo     = '0;
         new_hi     = '0;
         held_valid = 1'b0;
         held_lo    = '0;
         held_hi    = '0;
         new_placed = 1'b0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_NEW_START) new_lo = csr_wdata;
            else if (csr_index == CSR_NEW_END) new_hi = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            predict_merge_results(req_iv_start, req_iv_end, req_no_interval, req_list_last);
            n_requests++;
         end
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_spans.size() == 0) begin
               report_mismatch("result start with nothing expected", rsp_out_start, '0);
            end else begin
               want = expected_spans.pop_front();
               if (rsp_out_start !== want.lo) report_mismatch("out_start", rsp_out_start, want.lo);
               if (rsp_out_end !== want.hi) report_mismatch("out_end", rsp_out_end, want.hi);
               if (rsp_out_last !== want.last)
                  report_mismatch("out_last", value_type'(rsp_out_last), value_type'(want.last));
            end
         end
      end
      mismatch_count  <= mismatches;
      results_pending <= expected_spans.size();
      requests_seen   <= n_requests;
      results_seen    <= n_results;
   end

endmodule

### tb/sv/interval_insert_merge_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_insert_merge_tb
// Drives sorted, unsorted and empty interval lists through the insert-and-merge
// block under several register settings, with random gaps on both streams and
// one long result hold-off; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module interval_insert_merge_tb import iim_pkg::*; ();

   localparam int VALUE_WIDTH         = 16;
   localparam int RANDOM_ITEMS        = 85;
   localparam int LONG_HOLD_CYCLES    = 120;
   localparam int HOLD_AFTER_REQUESTS = 60;
   // first result passes the queue and the output register; leave ample margin
   localparam int SETTLE_CYCLES       = 8;
   localparam int RUN_LIMIT_NS        = 2_000_000;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       csr_write_en    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index       = CSR_NEW_START;
   value_type                  csr_wdata       = '0;
   logic                       req_valid       = 1'b0;
   value_type                  req_iv_start    = '0;
   value_type                  req_iv_end      = '0;
   logic                       req_no_interval = 1'b0;
   logic                       req_list_last   = 1'b0;
   logic                       rsp_stall       = 1'b0;

   wire                        req_stall;
   wire                        rsp_valid;
   wire  [VALUE_WIDTH-1:0]     rsp_out_start;
   wire  [VALUE_WIDTH-1:0]     rsp_out_end;
   wire                        rsp_out_last;

   int mismatch_count;
   int results_pending;
   int requests_seen;
   int results_seen;

   int   lists_sent    = 0;
   int   settings_used = 0;
   logic sender_gaps   = 1'b1;
   // high while the long result hold-off runs; keeps the sender offering
   logic hold_active   = 1'b0;

   interval_insert_merge #(.VALUE_WIDTH(VALUE_WIDTH)) uut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_iv_start    (req_iv_start),
      .req_iv_end      (req_iv_end),
      .req_no_interval (req_no_interval),
      .req_list_last   (req_list_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_start   (rsp_out_start),
      .rsp_out_end     (rsp_out_end),
      .rsp_out_last    (rsp_out_last)
   );

   interval_insert_merge_checker #(.VALUE_WIDTH(VALUE_WIDTH)) merge_check (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_iv_start    (req_iv_start),
      .req_iv_end      (req_iv_end),
      .req_no_interval (req_no_interval),
      .req_list_last   (req_list_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_start   (rsp_out_start),
      .rsp_out_end     (rsp_out_end),
      .rsp_out_last    (rsp_out_last),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .requests_seen   (requests_seen),
      .results_seen    (results_seen)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic value_type rand_value();
      return value_type'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic value_type clip(input int v);
      if (v > 16'hFFFF) return 16'hFFFF;
      return value_type'(v);
   endfunction

   // Offer one request and hold it until accepted. Called at a clock edge,
   // returns at the edge that took the request.
   task automatic send_request(input value_type lo, input value_type hi,
                               input logic none, input logic last);
      int gap;
      gap = 0;
      if (sender_gaps && $urandom_range(0, 3) == 0) gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_iv_start    <= lo;
      req_iv_end      <= hi;
      req_no_interval <= none;
      req_list_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (last) lists_sent++;
   endtask

   // Drop valid, wait until every predicted result has come back, then let
   // the pipeline settle so an idle request still in flight is done too.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_write_en high; the caller drops it.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input value_type val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
   endtask

   task automatic apply_setting(input value_type lo, input value_type hi);
      wait_for_drain();
      write_csr(CSR_NEW_START, lo);
      write_csr(CSR_NEW_END, hi);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic apply_random_setting();
      value_type lo;
      value_type hi;
      case ($urandom_range(0, 5))
         0: begin
            // corners of the value range
            lo = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            hi = $urandom_range(0, 1) ? 16'hFFFF : lo;
         end
         1: begin
            lo = rand_value();
            hi = clip(lo + $urandom_range(0, 20000));
         end
         2: begin
            // end below start
            hi = value_type'($urandom_range(0, 1500));
            lo = clip(hi + $urandom_range(1, 800));
         end
         default: begin
            // near the dense lists so merges are frequent
            lo = value_type'($urandom_range(0, 2000));
            hi = clip(lo + $urandom_range(0, 300));
         end
      endcase
      apply_setting(lo, hi);
   endtask

   task automatic directed_lists();
      apply_setting(16'd100, 16'd200);
      // empty list yields only the new interval
      send_request(16'd0, 16'd0, 1'b1, 1'b1);
      // idle request, nothing should come of it
      send_request(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      // all listed intervals ahead of the new one, no merge among them
      send_request(16'd10, 16'd20, 1'b0, 1'b0);
      send_request(16'd30, 16'd40, 1'b0, 1'b1);
      // insert mid list, merge overlapping and touching neighbors
      send_request(16'd50, 16'd60, 1'b0, 1'b0);
      send_request(16'd150, 16'd180, 1'b0, 1'b0);
      send_request(16'd190, 16'd300, 1'b0, 1'b0);
      send_request(16'd300, 16'd310, 1'b0, 1'b0);
      send_request(16'd400, 16'hFFFF, 1'b0, 1'b1);
      // equal start stays ahead of the new interval
      send_request(16'd100, 16'd105, 1'b0, 1'b0);
      send_request(16'd120, 16'd130, 1'b0, 1'b1);
      // one request causing three results
      send_request(16'd10, 16'd20, 1'b0, 1'b0);
      send_request(16'd500, 16'd600, 1'b0, 1'b1);
      // non-empty list closed by an interval-free last request
      send_request(16'd201, 16'd250, 1'b0, 1'b0);
      send_request(16'd0, 16'd0, 1'b1, 1'b1);

      apply_setting(16'hFFFF, 16'hFFFF);
      send_request(16'd0, 16'd0, 1'b0, 1'b0);
      send_request(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);

      apply_setting(16'd0, 16'd0);
      send_request(16'd0, 16'd0, 1'b0, 1'b0);
      send_request(16'd1, 16'd1, 1'b0, 1'b0);
      send_request(16'hFFFF, 16'd0, 1'b0, 1'b1);

      // new interval swallows everything, with malformed and unsorted input
      apply_setting(16'd0, 16'hFFFF);
      send_request(16'd5, 16'd10, 1'b0, 1'b0);
      send_request(16'd3, 16'd2, 1'b0, 1'b0);
      send_request(16'h8000, 16'h7FFF, 1'b0, 1'b1);

      // new end below its start
      apply_setting(16'd500, 16'd10);
      send_request(16'h5555, 16'hAAAA, 1'b0, 1'b0);
      send_request(16'hAAAA, 16'h5555, 1'b0, 1'b1);
   endtask

   task automatic random_lists();
      int        sent;
      int        list_no;
      int        len;
      int        kind;
      int        cur;
      int        reach;
      int        step_max;
      logic      close_empty;
      value_type lo;
      value_type hi;
      sent    = 0;
      list_no = 0;
      while (sent < RANDOM_ITEMS) begin
         // keep offering through the long hold-off, no drain for a new setting
         if (list_no % 3 == 0 && !hold_active) apply_random_setting();
         list_no++;
         // some lists run with no sender gaps at all
         sender_gaps = ($urandom_range(0, 3) != 0);
         len         = $urandom_range(0, 7);
         kind        = $urandom_range(0, 9);
         close_empty = ($urandom_range(0, 5) == 0);
         if (kind < 4) begin
            step_max = 16000;
            reach    = 20000;
            cur      = $urandom_range(0, 4000);
         end else begin
            step_max = 120;
            reach    = 150;
            cur      = $urandom_range(0, 2500);
         end
         if (len == 0) begin
            send_request(rand_value(), rand_value(), 1'b1, 1'b1);
            sent++;
         end else begin
            for (int k = 0; k < len; k++) begin
               // sprinkle idle requests, not counted
               if ($urandom_range(0, 9) == 0)
                  send_request(rand_value(), rand_value(), 1'b1, 1'b0);
               if (kind < 2) begin
                  // broken list: unsorted, ends anywhere
                  lo = rand_value();
                  hi = rand_value();
               end else begin
                  cur = cur + $urandom_range(0, step_max);
                  lo  = clip(cur);
                  hi  = clip(cur + $urandom_range(0, reach));
               end
               send_request(lo, hi, 1'b0, (k == len - 1) && !close_empty);
               sent++;
            end
            if (close_empty) begin
               send_request(rand_value(), rand_value(), 1'b1, 1'b1);
               sent++;
            end
         end
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      directed_lists();
      random_lists();
      wait_for_drain();
      $display("Covered %0d requests in %0d lists under %0d register settings.",
               requests_seen, lists_sent, settings_used);
      $display("Checked %0d result intervals, %0d mismatches, one long result hold-off.",
               results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Result side: random stalls, quiet stretches, and one long hold-off once
   // enough requests have gone in, so the block backs up onto its input.
   initial begin : result_sink
      int   gap_left;
      int   hold_left;
      int   phase_left;
      logic held_off;
      logic quiet;
      logic next_stall;
      gap_left   = 0;
      hold_left  = 0;
      phase_left = 0;
      held_off   = 1'b0;
      quiet      = 1'b0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            quiet      = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(20, 60);
         end else begin
            phase_left--;
         end
         // start the hold-off only while the sender is offering a request
         if (!held_off && requests_seen >= HOLD_AFTER_REQUESTS && req_valid) begin
            held_off  = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            next_stall = 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            gap_left   = pick_gap() - 1;
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
         end
         hold_active = (hold_left > 0);
         rsp_stall <= next_stall;
      end
   end

   // Hard stop well past the slowest legal run.
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("FAIL");
      $finish;
   end

endmodule
